// ----- sv/tmgr_pkg.sv -----
// Shared types and constants for the text-mode glyph renderer.
// Used by tmgr_ctrl, tmgr_dp and text_mode_glyph_renderer; no dependencies.
package tmgr_pkg;

    localparam int FONT_WIDTH       = 8;
    localparam int MAX_GLYPH_HEIGHT = 8;
    localparam int GLYPH_COUNT      = 256;
    localparam int STORE_DEPTH      = 2048;
    localparam int STORE_AW         = $clog2(STORE_DEPTH);
    localparam int ROW_AW           = $clog2(MAX_GLYPH_HEIGHT);
    localparam int COL_AW           = $clog2(FONT_WIDTH);

    localparam int ADDR_W   = 26;
    localparam int COLOUR_W = 32;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 32;

    // Input commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_RENDER = 2'd1;
    localparam logic [1:0] CMD_FRAME  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] REG_FRAME_ORIGIN  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_TEXT_COLUMNS  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_TEXT_ROWS     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_GLYPH_HEIGHT  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_BACKGROUND    = 3'd5;
    localparam logic [CFG_IW-1:0] REG_LAYER_VISIBLE = 3'd6;
    localparam logic [CFG_IW-1:0] REG_OVERLAY_MODE  = 3'd7;

    typedef struct packed {
        logic [1:0]          command;
        logic [STORE_AW-1:0] font_address;
        logic [7:0]          font_byte;
        logic [7:0]          char_code;
        logic [COLOUR_W-1:0] foreground_colour;
        logic                reverse_video;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]   pixel_address;
        logic [COLOUR_W-1:0] pixel_colour;
        logic                write_enable;
        logic                last_pixel;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;
        logic frame_clr;
        logic latch_cell;
        logic calc_stride;
        logic calc_base;
        logic fetch;
        logic emit;
        logic advance_pos;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic visible;
        logic fetch_done;
        logic last_pixel;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- sv/text_mode_glyph_renderer.sv -----
// Text-mode glyph renderer: top level joining tmgr_ctrl and tmgr_dp.
// Depends on tmgr_pkg.
//
// Use: load font bytes with command items (load), then send one render item
// per text cell; a frame-start item returns the cell position to the top left.
// Input channel: i_in_valid / i_in_data, the block drives o_in_stall. Output
// channel: o_out_valid / o_out_data, the receiver drives i_out_stall. An item
// moves at a clock edge with valid high and stall low.
// Configuration: i_cfg_we writes i_cfg_data into the register named by
// i_cfg_index; write only while the block is idle.
// Load, frame-start, hidden or unknown items leave the controller idle. A
// visible render item with glyph height h steps through the setup states
// S_STRIDE and S_BASE for the stride and base multiplies, then S_FETCH, which
// reads h glyph rows through the single store read port, then S_EMIT, one
// pixel per cycle (8*h pixels) into the output register while the output does not stall.
// No new item is accepted until the last pixel of the cell is emitted.
// Reset (synchronous, active low) returns the registers to their defaults,
// the cell position to zero and empties the output register; the glyph store
// keeps whatever it held and must be loaded before use.
// Output stall holds the pixel walk; the last pixel of a cell may still wait
// in the output register while the next input item is accepted.
module text_mode_glyph_renderer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tmgr_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [tmgr_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    input  tmgr_pkg::t_in_item          i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output tmgr_pkg::t_out_item         o_out_data,
    input  logic                        i_out_stall
);

    tmgr_pkg::t_dp_cmd dp_cmd;
    tmgr_pkg::t_dp_sts dp_sts;

    // Sequencer: accepts items in idle, steps setup, fetch and pixel emit
    tmgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Datapath: glyph store, address arithmetic, output register
    tmgr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- sv/tmgr_ctrl.sv -----
// Sequencing state machine of the glyph renderer.
// Depends on tmgr_pkg; drives tmgr_dp through t_dp_cmd.
module tmgr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_command,
    output logic              o_in_stall,
    input  tmgr_pkg::t_dp_sts i_sts,
    output tmgr_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_STRIDE = 5'b00010,
        S_BASE   = 5'b00100,
        S_FETCH  = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_wr   = (i_command == tmgr_pkg::CMD_LOAD);
                    o_cmd.frame_clr = (i_command == tmgr_pkg::CMD_FRAME);
                    if (i_command == tmgr_pkg::CMD_RENDER && i_sts.visible) begin
                        o_cmd.latch_cell = 1'b1;
                        n_state          = S_STRIDE;
                    end
                end
            end
            S_STRIDE: begin
                o_cmd.calc_stride = 1'b1;
                n_state           = S_BASE;
            end
            S_BASE: begin
                o_cmd.calc_base = 1'b1;
                n_state         = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (i_sts.fetch_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_pixel) begin
                        o_cmd.advance_pos = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/tmgr_dp.sv -----
// Datapath of the glyph renderer: configuration, glyph store, row buffer,
// address walk, cell position and output register. Depends on tmgr_pkg.
module tmgr_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tmgr_pkg::CFG_IW-1:0]      i_cfg_index,
    input  logic [tmgr_pkg::CFG_DW-1:0]      i_cfg_data,
    input  tmgr_pkg::t_in_item               i_in_data,
    input  tmgr_pkg::t_dp_cmd                i_cmd,
    output tmgr_pkg::t_dp_sts                o_sts,
    output logic                             o_out_valid,
    output tmgr_pkg::t_out_item              o_out_data,
    input  logic                             i_out_stall
);

    localparam int AW  = tmgr_pkg::ADDR_W;
    localparam int CW  = tmgr_pkg::COLOUR_W;
    localparam int SAW = tmgr_pkg::STORE_AW;
    localparam int RAW = tmgr_pkg::ROW_AW;
    localparam int XAW = tmgr_pkg::COL_AW;

    // Configuration registers
    logic [AW-1:0] r_origin;
    logic [12:0]   r_width;
    logic [9:0]    r_cols;
    logic [8:0]    r_rows;
    logic [3:0]    r_gh;
    logic [CW-1:0] r_bg;
    logic          r_visible;
    logic          r_overlay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin  <= '0;
            r_width   <= 13'd640;
            r_cols    <= 10'd80;
            r_rows    <= 9'd30;
            r_gh      <= 4'd8;
            r_bg      <= '0;
            r_visible <= 1'b1;
            r_overlay <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tmgr_pkg::REG_FRAME_ORIGIN:  r_origin  <= i_cfg_data[AW-1:0];
                tmgr_pkg::REG_SCREEN_WIDTH:  r_width   <= i_cfg_data[12:0];
                tmgr_pkg::REG_TEXT_COLUMNS:  r_cols    <= i_cfg_data[9:0];
                tmgr_pkg::REG_TEXT_ROWS:     r_rows    <= i_cfg_data[8:0];
                tmgr_pkg::REG_GLYPH_HEIGHT:  r_gh      <= i_cfg_data[3:0];
                tmgr_pkg::REG_BACKGROUND:    r_bg      <= i_cfg_data[CW-1:0];
                tmgr_pkg::REG_LAYER_VISIBLE: r_visible <= i_cfg_data[0];
                tmgr_pkg::REG_OVERLAY_MODE:  r_overlay <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamped register views
    logic [3:0]     h_c;
    logic [RAW-1:0] hm1;
    logic [12:0]    w_c;
    logic [9:0]     cols_c;
    logic [8:0]     rows_c;

    always_comb begin
        if (r_gh == 4'd0) begin
            h_c = 4'd1;
        end else if (r_gh > 4'(tmgr_pkg::MAX_GLYPH_HEIGHT)) begin
            h_c = 4'(tmgr_pkg::MAX_GLYPH_HEIGHT);
        end else begin
            h_c = r_gh;
        end
        hm1 = RAW'(h_c - 4'd1);
        if (r_width == 13'd0) begin
            w_c = 13'd1;
        end else if (r_width > 13'd4096) begin
            w_c = 13'd4096;
        end else begin
            w_c = r_width;
        end
        if (r_cols == 10'd0) begin
            cols_c = 10'd1;
        end else if (r_cols > 10'd512) begin
            cols_c = 10'd512;
        end else begin
            cols_c = r_cols;
        end
        if (r_rows == 9'd0) begin
            rows_c = 9'd1;
        end else if (r_rows > 9'd256) begin
            rows_c = 9'd256;
        end else begin
            rows_c = r_rows;
        end
    end

    // Latched cell
    logic [7:0]    r_ch;
    logic [CW-1:0] r_fg;
    logic          r_rev;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_cell) begin
            r_ch  <= i_in_data.char_code;
            r_fg  <= i_in_data.foreground_colour;
            r_rev <= i_in_data.reverse_video;
        end
    end

    // Cell position
    logic [8:0] r_col;
    logic [7:0] r_row;
    logic [9:0] col_inc;
    logic [8:0] row_inc;

    assign col_inc = {1'b0, r_col} + 10'd1;
    assign row_inc = {1'b0, r_row} + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.frame_clr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.advance_pos) begin
            if (col_inc >= cols_c) begin
                r_col <= '0;
                r_row <= (row_inc >= rows_c) ? 8'd0 : row_inc[7:0];
            end else begin
                r_col <= col_inc[8:0];
            end
        end
    end

    // Row stride, glyph base and cell base address
    logic [15:0]    r_stride;
    logic [SAW-1:0] r_gbase;
    logic [23:0]    row_off;
    logic [AW-1:0]  base_next;

    assign row_off   = 24'(r_row) * 24'(r_stride);
    assign base_next = r_origin + AW'(row_off) + AW'({r_col, 3'b000});

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_stride) begin
            r_stride <= 16'({cols_c, 3'b000}) + 16'(w_c) * 16'(hm1);
            r_gbase  <= SAW'(12'(r_ch) * 12'(h_c));
        end
    end

    // Glyph store and row buffer
    logic [7:0]     mem [tmgr_pkg::STORE_DEPTH];
    logic [7:0]     r_rd_data;
    logic [RAW-1:0] r_rd_slot;
    logic           r_rd_pend;
    logic [3:0]     r_fy;
    logic [7:0]     r_rowbuf [tmgr_pkg::MAX_GLYPH_HEIGHT];
    logic           fetch_rd;

    assign fetch_rd = i_cmd.fetch && (r_fy < h_c);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            mem[i_in_data.font_address] <= i_in_data.font_byte;
        end
        if (fetch_rd) begin
            r_rd_data <= mem[r_gbase + SAW'(r_fy)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_fy      <= '0;
        end else begin
            r_rd_pend <= fetch_rd;
            if (i_cmd.calc_base) begin
                r_fy <= '0;
            end else if (fetch_rd) begin
                r_fy <= r_fy + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch_rd) begin
            r_rd_slot <= RAW'(r_fy);
        end
        if (r_rd_pend) begin
            r_rowbuf[r_rd_slot] <= r_rev ? ~r_rd_data : r_rd_data;
        end
    end

    // Pixel walk, column-major
    logic [XAW-1:0] r_x;
    logic [RAW-1:0] r_y;
    logic [AW-1:0]  r_addr;
    logic [AW-1:0]  r_col_addr;
    logic           pix_bit;
    logic           col_end;
    logic           last;

    assign pix_bit = r_rowbuf[r_y][XAW'(tmgr_pkg::FONT_WIDTH - 1) - r_x];
    assign col_end = (r_y == hm1);
    assign last    = col_end && (r_x == XAW'(tmgr_pkg::FONT_WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_base) begin
            r_x        <= '0;
            r_y        <= '0;
            r_addr     <= base_next;
            r_col_addr <= base_next;
        end else if (i_cmd.emit) begin
            if (col_end) begin
                r_y        <= '0;
                r_x        <= r_x + XAW'(1);
                r_col_addr <= r_col_addr + AW'(1);
                r_addr     <= r_col_addr + AW'(1);
            end else begin
                r_y    <= r_y + RAW'(1);
                r_addr <= r_addr + AW'(w_c);
            end
        end
    end

    // Output register
    logic                r_out_valid;
    tmgr_pkg::t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.pixel_address <= r_addr;
            r_out_data.last_pixel    <= last;
            if (pix_bit) begin
                r_out_data.pixel_colour <= r_fg;
                r_out_data.write_enable <= 1'b1;
            end else if (!r_overlay) begin
                r_out_data.pixel_colour <= r_bg;
                r_out_data.write_enable <= 1'b1;
            end else begin
                r_out_data.pixel_colour <= '0;
                r_out_data.write_enable <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.visible    = r_visible;
    assign o_sts.fetch_done = (r_fy == h_c);
    assign o_sts.last_pixel = last;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

endmodule

// ----- verif/glyph_pixel_checker.sv -----
`timescale 1ns / 1ps
// Pixel checker for the text-mode glyph renderer: mirrors the glyph store, the
// registers and the cell position, predicts every pixel and compares in order.
// Depends on tmgr_pkg; instantiated by testbench next to the renderer.
module glyph_pixel_checker
    import tmgr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  t_in_item          i_in_data,
    input  logic              i_in_stall,
    input  logic              i_out_valid,
    input  t_out_item         i_out_data,
    input  logic              i_out_stall,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    logic [7:0]          font_copy [STORE_DEPTH];
    logic [ADDR_W-1:0]   origin;
    logic [12:0]         width_reg;
    logic [9:0]          columns_reg;
    logic [8:0]          rows_reg;
    logic [3:0]          height_reg;
    logic [COLOUR_W-1:0] background;
    logic                visible;
    logic                overlay;
    logic [8:0]          cell_col;
    logic [7:0]          cell_row;
    t_out_item           expected_pixels [$];
    t_out_item           want;

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Update the mirrored state for one item and queue the pixels it draws.
    task automatic predict_pixels(input t_in_item item);
        int unsigned h, w, cols, rows;
        logic [63:0] base, addr;
        logic [7:0]  glyph_row;
        t_out_item   px;
        case (item.command)
            CMD_LOAD: font_copy[item.font_address] = item.font_byte;
            CMD_FRAME: begin
                cell_col = '0;
                cell_row = '0;
            end
            CMD_RENDER: if (visible) begin
                h    = clamp_to(height_reg, 1, MAX_GLYPH_HEIGHT);
                w    = clamp_to(width_reg, 1, 4096);
                cols = clamp_to(columns_reg, 1, 512);
                rows = clamp_to(rows_reg, 1, 256);
                base = 64'(origin)
                     + 64'(cell_row) * (64'(cols) * FONT_WIDTH + 64'(w) * (h - 1))
                     + 64'(cell_col) * FONT_WIDTH;
                // column-major walk: left column top to bottom first
                for (int x = 0; x < FONT_WIDTH; x++) begin
                    for (int y = 0; y < int'(h); y++) begin
                        glyph_row = font_copy[(int'(item.char_code) * h + y) % STORE_DEPTH];
                        if (item.reverse_video) glyph_row = ~glyph_row;
                        addr = base + 64'(x) + 64'(y) * 64'(w);
                        px.pixel_address = addr[ADDR_W-1:0];
                        if (glyph_row[FONT_WIDTH-1-x]) begin
                            px.pixel_colour = item.foreground_colour;
                            px.write_enable = 1'b1;
                        end else if (!overlay) begin
                            px.pixel_colour = background;
                            px.write_enable = 1'b1;
                        end else begin
                            px.pixel_colour = '0;
                            px.write_enable = 1'b0;
                        end
                        px.last_pixel = (x == FONT_WIDTH - 1) && (y == int'(h) - 1);
                        expected_pixels.push_back(px);
                    end
                end
                // a position left beyond a reduced size wraps on this advance
                if (int'(cell_col) + 1 >= int'(cols)) begin
                    cell_col = '0;
                    if (int'(cell_row) + 1 >= int'(rows)) cell_row = '0;
                    else cell_row = cell_row + 1'b1;
                end else begin
                    cell_col = cell_col + 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            origin       = '0;
            width_reg    = 13'd640;
            columns_reg  = 10'd80;
            rows_reg     = 9'd30;
            height_reg   = 4'd8;
            background   = '0;
            visible      = 1'b1;
            overlay      = 1'b0;
            cell_col     = '0;
            cell_row     = '0;
            o_fail_count = 0;
            o_checked    = 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_ORIGIN:  origin      = i_cfg_data[ADDR_W-1:0];
                    REG_SCREEN_WIDTH:  width_reg   = i_cfg_data[12:0];
                    REG_TEXT_COLUMNS:  columns_reg = i_cfg_data[9:0];
                    REG_TEXT_ROWS:     rows_reg    = i_cfg_data[8:0];
                    REG_GLYPH_HEIGHT:  height_reg  = i_cfg_data[3:0];
                    REG_BACKGROUND:    background  = i_cfg_data[COLOUR_W-1:0];
                    REG_LAYER_VISIBLE: visible     = i_cfg_data[0];
                    REG_OVERLAY_MODE:  overlay     = i_cfg_data[0];
                    default: ;
                endcase
            end
            // compare before queueing so a stray pixel is never masked
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel: address %0h colour %0h",
                           i_out_data.pixel_address, i_out_data.pixel_colour);
                    o_fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    o_checked++;
                    if (i_out_data.pixel_address !== want.pixel_address) begin
                        $error("pixel_address: expected %0h, actual %0h",
                               want.pixel_address, i_out_data.pixel_address);
                        o_fail_count++;
                    end
                    if (i_out_data.pixel_colour !== want.pixel_colour) begin
                        $error("pixel_colour: expected %0h, actual %0h",
                               want.pixel_colour, i_out_data.pixel_colour);
                        o_fail_count++;
                    end
                    if (i_out_data.write_enable !== want.write_enable) begin
                        $error("write_enable: expected %0b, actual %0b",
                               want.write_enable, i_out_data.write_enable);
                        o_fail_count++;
                    end
                    if (i_out_data.last_pixel !== want.last_pixel) begin
                        $error("last_pixel: expected %0b, actual %0b",
                               want.last_pixel, i_out_data.last_pixel);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_pixels(i_in_data);
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Top of the text-mode glyph renderer testbench: clock, reset, stimulus,
// output back-pressure and the verdict. Depends on tmgr_pkg, the renderer
// and glyph_pixel_checker.
module testbench;
    import tmgr_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 8;
    // enough for a visible 8-row cell to finish, with margin on top of that
    localparam int SETTLE_CYCLES    = 100;
    localparam int LONG_HOLD_CYCLES = 700;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 10;
    localparam int HOLD_PHASE       = 1;
    localparam int PAUSE_PHASE      = 3;
    // the first few codes are loaded at every height, the last code at full height
    localparam int LOW_CHARS        = 4;
    localparam int LOW_FILL         = LOW_CHARS * MAX_GLYPH_HEIGHT;
    localparam int TOP_FILL         = (GLYPH_COUNT - 1) * MAX_GLYPH_HEIGHT;
    // the command encoding the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]   origin;
        logic [12:0]         width;
        logic [9:0]          columns;
        logic [8:0]          rows;
        logic [3:0]          height;
        logic [COLOUR_W-1:0] background;
        logic                visible;
        logic                overlay;
    } display_setup_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_IW-1:0] cfg_index = REG_FRAME_ORIGIN;
    logic [CFG_DW-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    t_in_item          in_data   = '0;
    logic              in_stall;
    logic              out_valid;
    t_out_item         out_data;
    logic              out_stall = 1'b0;

    int   fail_count;
    int   pending_pixels;
    int   pixels_checked;
    int   items_sent     = 0;
    int   setups_written = 0;
    int   cycle_count    = 0;
    // idling odds in percent per item (sender) and per cycle (receiver)
    int   gap_pct        = 0;
    int   stall_pct      = 0;
    logic hold_armed     = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_left      = 0;
    int   stall_burst    = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    text_mode_glyph_renderer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    glyph_pixel_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_data    (in_data),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_data   (out_data),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending_pixels),
        .o_checked    (pixels_checked)
    );

    // Hard stop: a hung handshake must not run forever.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still due", cycle_count,
                     pending_pixels);
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure. The one long hold-off is counted here, on its
    // own, so the sender keeps offering items while the block backs up.
    always @(posedge clk) begin
        if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_burst != 0 && stall_pct != 0) begin
            stall_burst--;
            out_stall <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            stall_burst = $urandom_range(19, 1) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Random content everywhere; callers pin the fields that matter.
    function automatic t_in_item rand_item(input logic [1:0] cmd);
        t_in_item item;
        item.command           = cmd;
        item.font_address      = STORE_AW'($urandom_range(STORE_DEPTH - 1));
        item.font_byte         = 8'($urandom_range(255));
        item.char_code         = 8'($urandom_range(255));
        item.foreground_colour = $urandom;
        item.reverse_video     = 1'($urandom_range(1));
        return item;
    endfunction

    function automatic display_setup_t make_setup(
        input logic [ADDR_W-1:0]   origin,
        input logic [12:0]         width,
        input logic [9:0]          columns,
        input logic [8:0]          rows,
        input logic [3:0]          height,
        input logic [COLOUR_W-1:0] background,
        input logic                visible,
        input logic                overlay
    );
        display_setup_t s;
        s.origin     = origin;
        s.width      = width;
        s.columns    = columns;
        s.rows       = rows;
        s.height     = height;
        s.background = background;
        s.visible    = visible;
        s.overlay    = overlay;
        return s;
    endfunction

    // Offer one item, maybe after an idle burst, and return on the edge that
    // takes it. Valid stays high into the next item when there is no gap.
    task automatic send_item(input t_in_item item);
        int gap;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(19, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_render(input logic [7:0] ch, input logic [COLOUR_W-1:0] fg,
                               input logic rev);
        t_in_item item;
        item                   = rand_item(CMD_RENDER);
        item.char_code         = ch;
        item.foreground_colour = fg;
        item.reverse_video     = rev;
        send_item(item);
    endtask

    task automatic send_load(input logic [STORE_AW-1:0] addr, input logic [7:0] glyph_bits);
        t_in_item item;
        item              = rand_item(CMD_LOAD);
        item.font_address = addr;
        item.font_byte    = glyph_bits;
        send_item(item);
    endtask

    // Drop valid and hold until every predicted pixel has come out. Pending
    // count is read on the falling edge, away from the checker's update.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_pixels != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Program all eight registers back to back. Wait out the block's own
    // latency first: a hidden or ignored item may still be in flight.
    task automatic set_registers(input display_setup_t s);
        repeat (SETTLE_CYCLES) @(posedge clk);
        put_reg(REG_FRAME_ORIGIN,  CFG_DW'(s.origin));
        put_reg(REG_SCREEN_WIDTH,  CFG_DW'(s.width));
        put_reg(REG_TEXT_COLUMNS,  CFG_DW'(s.columns));
        put_reg(REG_TEXT_ROWS,     CFG_DW'(s.rows));
        put_reg(REG_GLYPH_HEIGHT,  CFG_DW'(s.height));
        put_reg(REG_BACKGROUND,    CFG_DW'(s.background));
        put_reg(REG_LAYER_VISIBLE, CFG_DW'(s.visible));
        put_reg(REG_OVERLAY_MODE,  CFG_DW'(s.overlay));
        cfg_we <= 1'b0;
        setups_written++;
    endtask

    initial begin
        display_setup_t s;
        t_in_item       item;
        int             pick;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the rows of the first few codes for every glyph height and the
        // rows of the last code at full height. Renders stick to those codes,
        // so no render reads an entry that was never written.
        gap_pct = 10;
        stall_pct <= 10;
        for (int a = 0; a < LOW_FILL; a++)
            send_load(STORE_AW'(a), (a == 0) ? 8'h00 : 8'($urandom));
        for (int a = TOP_FILL; a < STORE_DEPTH; a++)
            send_load(STORE_AW'(a), (a == STORE_DEPTH - 1) ? 8'hFF : 8'($urandom));

        // Directed: reset settings, code and colour extremes, reverse video,
        // the ignored command, frame start and reloads of the edge entries.
        send_render(8'h00, 32'h0000_0000, 1'b0);
        send_render(8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_render(8'hFF, 32'h1234_5678, 1'b0);
        send_item(rand_item(CMD_UNUSED));
        send_item(rand_item(CMD_FRAME));
        send_load(STORE_AW'(STORE_DEPTH - 1), 8'h00);
        send_load('0, 8'hFF);
        send_render(8'h00, 32'h8000_0001, 1'b1);
        send_render(8'hFF, $urandom, 1'b0);

        // Largest sizes, origin at the top so addresses wrap; overlay on.
        wait_drained();
        set_registers(make_setup('1, 13'd4096, 10'd512, 9'd256, 4'd8, '1, 1'b1, 1'b1));
        send_render(8'h03, $urandom, 1'b0);
        send_render(8'hFF, $urandom, 1'b1);

        // Smallest sizes: one-row glyphs, a one-cell screen that wraps each time.
        wait_drained();
        set_registers(make_setup('0, 13'd1, 10'd1, 9'd1, 4'd1, 32'h00FF_00FF, 1'b1, 1'b0));
        send_render(8'h1F, $urandom, 1'b0);
        send_render(8'h11, $urandom, 1'b1);

        // Register values above the clamp limits, then below them.
        wait_drained();
        set_registers(make_setup(26'h0001234, '1, '1, '1, '1, $urandom, 1'b1, 1'b0));
        send_render(8'h02, $urandom, 1'b0);
        send_render(8'hFF, $urandom, 1'b1);
        wait_drained();
        set_registers(make_setup(26'h2000000, '0, '0, '0, '0, $urandom, 1'b1, 1'b1));
        send_render(8'h10, $urandom, 1'b0);
        send_render(8'h1E, $urandom, 1'b1);

        // Hidden layer: renders draw nothing and leave the position alone.
        wait_drained();
        set_registers(make_setup('0, 13'd640, 10'd80, 9'd30, 4'd8, '0, 1'b0, 1'b0));
        send_render(8'h20, $urandom, 1'b0);
        send_item(rand_item(CMD_FRAME));
        send_render(8'h21, $urandom, 1'b1);

        // Walk a few cells along, then shrink the column count under the
        // current position: that cell is still drawn, the next one wraps.
        wait_drained();
        set_registers(make_setup(26'h0000400, 13'd640, 10'd80, 9'd30, 4'd8, $urandom,
                                 1'b1, 1'b0));
        send_render(8'h00, $urandom, 1'b0);
        send_render(8'h01, $urandom, 1'b0);
        send_render(8'h02, $urandom, 1'b1);
        wait_drained();
        set_registers(make_setup(26'h0000400, 13'd640, 10'd2, 9'd30, 4'd8, $urandom,
                                 1'b1, 1'b0));
        send_render(8'h03, $urandom, 1'b0);
        send_render(8'hFF, $urandom, 1'b1);

        // Random phases: a fresh register setup each, mostly renders with
        // loads, frame starts and the odd ignored command mixed in.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            case ($urandom_range(2))
                0:       s.origin = '0;
                1:       s.origin = '1;
                default: s.origin = ADDR_W'($urandom);
            endcase
            s.width = ($urandom_range(4) == 0) ? 13'($urandom) : 13'($urandom_range(4096, 1));
            case ($urandom_range(3))
                0:       s.columns = 10'($urandom_range(4, 1));
                1:       s.columns = 10'($urandom);
                default: s.columns = 10'($urandom_range(512, 1));
            endcase
            case ($urandom_range(3))
                0:       s.rows = 9'($urandom_range(3, 1));
                1:       s.rows = 9'($urandom);
                default: s.rows = 9'($urandom_range(256, 1));
            endcase
            s.height     = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
            s.background = $urandom;
            s.visible    = ($urandom_range(5) != 0);
            s.overlay    = 1'($urandom_range(1));
            // the hold-off phase needs pixels to back the block up
            if (p == HOLD_PHASE) s.visible = 1'b1;
            set_registers(s);

            if (p == RANDOM_PHASES - 1) begin
                // last stretch runs flat out on both sides
                gap_pct = 0;
                stall_pct <= 0;
            end else begin
                case ($urandom_range(2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(2))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 15;
                    default: stall_pct <= 40;
                endcase
            end
            if (p == HOLD_PHASE) hold_armed <= 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // pause the sender once until the output side has caught up
                if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) wait_drained();
                pick = $urandom_range(99);
                if (pick < 70) begin
                    // codes loaded for every height
                    item           = rand_item(CMD_RENDER);
                    item.char_code = 8'($urandom_range(LOW_CHARS - 1));
                end else if (pick < 82) begin
                    item = rand_item(CMD_LOAD);
                end else if (pick < 96) begin
                    item = rand_item(CMD_FRAME);
                end else begin
                    item = rand_item(CMD_UNUSED);
                end
                send_item(item);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d items accepted (glyph store fill included), %0d pixels compared",
                 items_sent, pixels_checked);
        $display("summary: %0d register setups, with clamped, hidden and overlay settings",
                 setups_written);
        if (fail_count == 0 && pending_pixels == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
